### sv/rde_pkg.sv
// Shared types and constants of the reversible deque engine.
`default_nettype none
package rde_pkg;

  localparam int OP_W        = 3;
  localparam int OUT_VALUE_W = 16;
  localparam int OUT_COUNT_W = 7;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LIST  = 2'd1;
  localparam logic [1:0] CMD_FUNC  = 2'd2;
  localparam logic [1:0] CMD_DRAIN = 2'd3;

  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  typedef enum logic [OP_W-1:0] {
    OP_NOP   = 3'd0,
    OP_CLEAR = 3'd1,
    OP_PUSH  = 3'd2,
    OP_REV   = 3'd3,
    OP_DROP  = 3'd4,
    OP_DRAIN = 3'd5
  } rde_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WAIT = 2'b10
  } rde_state_t;

endpackage
`default_nettype wire

### sv/rde_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/rde_front.sv
// Front end: accepts input transactions, parses list text and classifies operations.
`default_nettype none
module rde_front #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_command,
  input  wire logic [7:0]            in_char_code,
  output logic                       q_push,
  output rde_pkg::rde_op_t           q_op,
  output logic [DATA_WIDTH-1:0]      q_value,
  input  wire logic                  q_full
);
  import rde_pkg::*;

  localparam int SW = DATA_WIDTH + 4;

  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic                  pend_r, pend_nxt;
  logic [3:0]            digit;
  logic [SW-1:0]         acc_wide;
  logic                  is_digit;
  logic                  is_sep;
  rde_op_t               op;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_op     = op;
  assign q_value  = acc_r;

  assign is_digit = in_char_code inside {[CH_0:CH_9]};
  assign is_sep   = in_char_code inside {CH_COMMA, CH_RBRACK};
  assign digit    = 4'(in_char_code - CH_0);
  assign acc_wide = SW'({acc_r, 3'b000}) + SW'({acc_r, 1'b0}) + SW'(digit);

  always_comb begin
    op       = OP_NOP;
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    case (in_command)
      CMD_CLEAR: begin
        op       = OP_CLEAR;
        acc_nxt  = '0;
        pend_nxt = 1'b0;
      end
      CMD_LIST: begin
        if (is_digit) begin
          acc_nxt  = (acc_wide > SW'({DATA_WIDTH{1'b1}})) ? {DATA_WIDTH{1'b1}}
                                                          : acc_wide[DATA_WIDTH-1:0];
          pend_nxt = 1'b1;
        end else if (is_sep && pend_r) begin
          op       = OP_PUSH;
          acc_nxt  = '0;
          pend_nxt = 1'b0;
        end
      end
      CMD_FUNC: begin
        if (in_char_code == CH_R) begin
          op = OP_REV;
        end else if (in_char_code == CH_D) begin
          op = OP_DROP;
        end
      end
      CMD_DRAIN: begin
        op = OP_DRAIN;
      end
      default: begin
        op = OP_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= 1'b0;
    end else if (q_push) begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/rde_queue.sv
// Two-entry operation queue between the front end and the back end.
`default_nettype none
module rde_queue #(
  parameter int WIDTH = 19
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  nonempty
);

  localparam int QD = 2;

  logic [WIDTH-1:0] entry_r [QD];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full     = (count_r == 2'(QD));
  assign nonempty = (count_r != 2'd0);
  assign rdata    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/rde_back.sv
// Back end: ring buffer control, element store and the result register.
`default_nettype none
module rde_back #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  input  wire rde_pkg::rde_op_t                  q_op,
  input  wire logic [DATA_WIDTH-1:0]             q_value,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [rde_pkg::OUT_VALUE_W-1:0]        out_element_value,
  output logic                                   out_element_valid,
  output logic                                   out_is_last,
  output logic                                   out_error_flag,
  output logic                                   out_overflow_flag,
  output logic [rde_pkg::OUT_COUNT_W-1:0]        out_element_count
);
  import rde_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  rde_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          rev_r, rev_nxt;
  logic          err_r, err_nxt;
  logic          ovf_r, ovf_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_VALUE_W-1:0] value_r, value_nxt;
  logic                   elem_valid_r, elem_valid_nxt;
  logic                   last_r, last_nxt;
  logic                   err_out_r, err_out_nxt;
  logic                   ovf_out_r, ovf_out_nxt;
  logic [OUT_COUNT_W-1:0] count_r, count_nxt;

  logic                   out_free;
  logic                   take;
  logic                   load_now;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_rdata;
  logic [AW-1:0]          slot_fill;
  logic [AW-1:0]          slot_last;
  logic [AW-1:0]          slot_next;
  logic [AW-1:0]          head_dec;

  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] head,
                                            input logic [AW-1:0] offset);
    logic [AW:0] sum;
    sum = (AW+1)'(head) + (AW+1)'(offset);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign take      = (state_r == ST_IDLE) && q_valid && out_free;
  assign q_pop     = take;
  assign slot_fill = slot_at(head_r, AW'(fill_r));
  assign slot_last = slot_at(head_r, AW'(fill_r - FW'(1)));
  assign slot_next = slot_at(head_r, AW'(1));
  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);

  rde_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (q_value),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    rev_nxt   = rev_r;
    err_nxt   = err_r;
    ovf_nxt   = ovf_r;
    ram_we    = 1'b0;
    ram_waddr = slot_fill;
    ram_re    = 1'b0;
    ram_raddr = slot_last;
    load_now  = 1'b0;
    if (take) begin
      load_now = 1'b1;
      case (q_op)
        OP_CLEAR: begin
          head_nxt = '0;
          fill_nxt = '0;
          rev_nxt  = 1'b0;
          err_nxt  = 1'b0;
          ovf_nxt  = 1'b0;
        end
        OP_PUSH: begin
          if (fill_r == FW'(DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
            if (rev_r) begin
              head_nxt  = head_dec;
              ram_waddr = head_dec;
            end
          end
        end
        OP_REV: begin
          if (!err_r) begin
            rev_nxt = !rev_r;
          end
        end
        OP_DROP, OP_DRAIN: begin
          if (!err_r) begin
            if (fill_r == '0) begin
              err_nxt = (q_op == OP_DROP);
            end else begin
              fill_nxt = fill_r - FW'(1);
              if (!rev_r) begin
                head_nxt  = slot_next;
                ram_raddr = head_r;
              end
              if (q_op == OP_DRAIN) begin
                ram_re    = 1'b1;
                load_now  = 1'b0;
                state_nxt = ST_WAIT;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end else if (state_r == ST_WAIT) begin
      state_nxt = ST_IDLE;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    value_nxt      = value_r;
    elem_valid_nxt = elem_valid_r;
    last_nxt       = last_r;
    err_out_nxt    = err_out_r;
    ovf_out_nxt    = ovf_out_r;
    count_nxt      = count_r;
    if (load_now) begin
      out_valid_nxt  = 1'b1;
      value_nxt      = '0;
      elem_valid_nxt = 1'b0;
      last_nxt       = 1'b0;
      err_out_nxt    = err_nxt;
      ovf_out_nxt    = ovf_nxt;
      count_nxt      = OUT_COUNT_W'(fill_nxt);
    end else if (state_r == ST_WAIT) begin
      out_valid_nxt  = 1'b1;
      value_nxt      = OUT_VALUE_W'(ram_rdata);
      elem_valid_nxt = 1'b1;
      last_nxt       = (fill_r == '0);
      err_out_nxt    = err_r;
      ovf_out_nxt    = ovf_r;
      count_nxt      = OUT_COUNT_W'(fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      rev_r       <= 1'b0;
      err_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      rev_r       <= rev_nxt;
      err_r       <= err_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r      <= value_nxt;
    elem_valid_r <= elem_valid_nxt;
    last_r       <= last_nxt;
    err_out_r    <= err_out_nxt;
    ovf_out_r    <= ovf_out_nxt;
    count_r      <= count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_element_value = value_r;
  assign out_element_valid = elem_valid_r;
  assign out_is_last       = last_r;
  assign out_error_flag    = err_out_r;
  assign out_overflow_flag = ovf_out_r;
  assign out_element_count = count_r;

  // The result register must be free while a drain waits for its read data.
  a_wait_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAIT |-> !out_valid_r)
    else $error("drain read pending while result register busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("fill count exceeds depth");

  a_wait_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAIT |=> out_valid_r && elem_valid_r)
    else $error("drain did not produce an element");

  a_err_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    take && err_r && q_op != OP_CLEAR && q_op != OP_PUSH |=> fill_r == $past(fill_r))
    else $error("buffer changed after error");

endmodule
`default_nettype wire

### sv/reversible_deque_engine_unit.sv
// Each transaction yields exactly one result. Clear, list-character and function-character
// transactions finish in the back end when taken; a drain that returns an element waits in
// ST_WAIT, because the element store is a RAM with a registered read port. A two-entry queue
// between the parser and the buffer control lets the input side accept up to two further
// transactions while a result is stalled. The store needs no clearing pass after reset.
`default_nettype none
module reversible_deque_engine_unit #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_command,
  input  wire logic [7:0]                        in_char_code,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [rde_pkg::OUT_VALUE_W-1:0]        out_element_value,
  output logic                                   out_element_valid,
  output logic                                   out_is_last,
  output logic                                   out_error_flag,
  output logic                                   out_overflow_flag,
  output logic [rde_pkg::OUT_COUNT_W-1:0]        out_element_count
);
  import rde_pkg::*;

  localparam int QW = OP_W + DATA_WIDTH;

  logic                  f_push;
  rde_op_t               f_op;
  logic [DATA_WIDTH-1:0] f_value;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_nonempty;
  logic [QW-1:0]         q_wdata;
  logic [QW-1:0]         q_rdata;
  rde_op_t               b_op;
  logic [DATA_WIDTH-1:0] b_value;

  assign q_wdata = {f_op, f_value};
  assign b_op    = rde_op_t'(q_rdata[QW-1:DATA_WIDTH]);
  assign b_value = q_rdata[DATA_WIDTH-1:0];

  rde_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_char_code (in_char_code),
    .q_push       (f_push),
    .q_op         (f_op),
    .q_value      (f_value),
    .q_full       (q_full)
  );

  rde_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .nonempty (q_nonempty)
  );

  rde_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_nonempty),
    .q_op              (b_op),
    .q_value           (b_value),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_element_value (out_element_value),
    .out_element_valid (out_element_valid),
    .out_is_last       (out_is_last),
    .out_error_flag    (out_error_flag),
    .out_overflow_flag (out_overflow_flag),
    .out_element_count (out_element_count)
  );

endmodule
`default_nettype wire

### test/tb_reversible_deque_engine_unit.sv
// Self-checking testbench for the reversible deque engine: list loading, reverse, drop and drain.
module tb_reversible_deque_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rde_pkg::*;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 175;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_Q      = 8'h51;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_code;
  } deque_item_t;

  typedef struct packed {
    logic [15:0] value;
    logic        valid;
    logic        last;
    logic        err;
    logic        ovf;
    logic [6:0]  count;
  } deque_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_CLEAR;
  logic [7:0]  in_char_code = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [OUT_VALUE_W-1:0] out_element_value;
  logic        out_element_valid;
  logic        out_is_last;
  logic        out_error_flag;
  logic        out_overflow_flag;
  logic [OUT_COUNT_W-1:0] out_element_count;

  deque_item_t   pending_items[$];
  deque_result_t expected_results[$];
  deque_item_t   next_item;
  deque_result_t got_result;
  deque_result_t want_result;
  int            error_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  logic [15:0] model_store[DEPTH];
  int          model_head;
  int          model_fill;
  logic        model_rev;
  logic        model_err;
  logic        model_ovf;
  logic [15:0] model_acc;
  logic        model_pend;

  reversible_deque_engine_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_element_value (out_element_value),
    .out_element_valid (out_element_valid),
    .out_is_last       (out_is_last),
    .out_error_flag    (out_error_flag),
    .out_overflow_flag (out_overflow_flag),
    .out_element_count (out_element_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void deque_clear();
    model_head = 0;
    model_fill = 0;
    model_rev  = 1'b0;
    model_err  = 1'b0;
    model_ovf  = 1'b0;
    model_acc  = 16'h0000;
    model_pend = 1'b0;
  endfunction

  function automatic void deque_push_tail(input logic [15:0] v);
    if (model_fill >= DEPTH) begin
      model_ovf = 1'b1;
    end else if (model_rev) begin
      model_head = (model_head + DEPTH - 1) % DEPTH;
      model_store[model_head] = v;
      model_fill++;
    end else begin
      model_store[(model_head + model_fill) % DEPTH] = v;
      model_fill++;
    end
  endfunction

  function automatic logic [15:0] deque_take_head();
    logic [15:0] v;
    if (model_rev) begin
      v = model_store[(model_head + model_fill - 1) % DEPTH];
    end else begin
      v = model_store[model_head];
      model_head = (model_head + 1) % DEPTH;
    end
    model_fill--;
    return v;
  endfunction

  function automatic deque_result_t deque_predict(input deque_item_t it);
    deque_result_t r;
    logic [31:0]   acc;
    r = '0;
    case (it.command)
      CMD_CLEAR: begin
        deque_clear();
      end
      CMD_LIST: begin
        if (it.char_code >= CH_0 && it.char_code <= CH_9) begin
          acc = model_acc * 32'd10 + (it.char_code - CH_0);
          model_acc = (acc > 32'h0000FFFF) ? 16'hFFFF : acc[15:0];
          model_pend = 1'b1;
        end else if ((it.char_code == CH_COMMA || it.char_code == CH_RBRACK) && model_pend) begin
          deque_push_tail(model_acc);
          model_acc  = 16'h0000;
          model_pend = 1'b0;
        end
      end
      CMD_FUNC: begin
        if (!model_err) begin
          if (it.char_code == CH_R) begin
            model_rev = ~model_rev;
          end else if (it.char_code == CH_D) begin
            if (model_fill == 0) model_err = 1'b1;
            else void'(deque_take_head());
          end
        end
      end
      default: begin
        if (!model_err && model_fill > 0) begin
          r.value = deque_take_head();
          r.valid = 1'b1;
          r.last  = (model_fill == 0);
        end
      end
    endcase
    r.err   = model_err;
    r.ovf   = model_ovf;
    r.count = model_fill[6:0];
    return r;
  endfunction

  function automatic void add_item(input logic [1:0] cmd, input logic [7:0] ch);
    deque_item_t it;
    it.command   = cmd;
    it.char_code = ch;
    pending_items.push_front(it);
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] picks[6];
    picks = '{CH_R, CH_D, CH_COMMA, CH_RBRACK, CH_LBRACK, CH_0};
    if ($urandom_range(1) == 0) return 8'($urandom_range(255));
    if ($urandom_range(3) == 0) return 8'(CH_0 + $urandom_range(9));
    return picks[$urandom_range(5)];
  endfunction

  function automatic void add_number();
    int v;
    int digs[8];
    int nd;
    int k;
    case ($urandom_range(3))
      0: v = $urandom_range(9);
      1: v = $urandom_range(999);
      2: v = $urandom_range(65535);
      default: v = $urandom_range(999999, 65530);
    endcase
    if ($urandom_range(7) == 0) add_item(CMD_LIST, CH_0);
    nd = 0;
    do begin
      digs[nd] = v % 10;
      v = v / 10;
      nd++;
    end while (v > 0);
    for (k = nd - 1; k >= 0; k--) add_item(CMD_LIST, 8'(CH_0 + digs[k]));
  endfunction

  function automatic void add_case();
    int n;
    int nf;
    int k;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(12, 3)) add_item(2'($urandom_range(3)), noise_char());
      return;
    end
    add_item(CMD_CLEAR, 8'($urandom_range(255)));
    n = ($urandom_range(11) == 0) ? $urandom_range(70, 60) : $urandom_range(8);
    add_item(CMD_LIST, CH_LBRACK);
    for (k = 0; k < n; k++) begin
      add_number();
      if ($urandom_range(15) == 0) add_item(CMD_LIST, noise_char());
      add_item(CMD_LIST, (k == n - 1) ? CH_RBRACK : CH_COMMA);
    end
    if (n == 0) add_item(CMD_LIST, CH_RBRACK);
    nf = $urandom_range(5);
    for (k = 0; k < nf; k++) begin
      case ($urandom_range(6))
        0, 1, 2: add_item(CMD_FUNC, CH_R);
        3, 4, 5: add_item(CMD_FUNC, CH_D);
        default: add_item(CMD_FUNC, noise_char());
      endcase
    end
    repeat (n + $urandom_range(2)) add_item(CMD_DRAIN, 8'($urandom_range(255)));
  endfunction

  // Expectations are formed when a transaction is first presented, which always precedes its result.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_command   <= CMD_CLEAR;
      in_char_code <= 8'h00;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_back();
        in_valid     <= 1'b1;
        in_command   <= next_item.command;
        in_char_code <= next_item.char_code;
        expected_results.push_front(deque_predict(next_item));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_result = {out_element_value, out_element_valid, out_is_last, out_error_flag,
                      out_overflow_flag, out_element_count};
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: value=%0d valid=%0d last=%0d err=%0d ovf=%0d count=%0d",
                   $time, got_result.value, got_result.valid, got_result.last, got_result.err,
                   got_result.ovf, got_result.count);
        end else begin
          want_result = expected_results.pop_back();
          if (got_result !== want_result) begin
            error_count++;
            $display("%0t: mismatch: expected value=%0d valid=%0d last=%0d err=%0d ovf=%0d count=%0d",
                     $time, want_result.value, want_result.valid, want_result.last,
                     want_result.err, want_result.ovf, want_result.count);
            $display("%0t:           actual value=%0d valid=%0d last=%0d err=%0d ovf=%0d count=%0d",
                     $time, got_result.value, got_result.valid, got_result.last,
                     got_result.err, got_result.ovf, got_result.count);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int send_pcts[4];
    int recv_pcts[4];
    int ph;
    send_pcts = '{0, 66, 0, 31};
    recv_pcts = '{0, 0, 66, 31};
    deque_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    add_item(CMD_CLEAR, 8'h00);
    add_item(CMD_LIST, CH_LBRACK);
    add_item(CMD_LIST, 8'(CH_0 + 6));
    add_item(CMD_LIST, 8'(CH_0 + 5));
    add_item(CMD_LIST, 8'(CH_0 + 5));
    add_item(CMD_LIST, 8'(CH_0 + 3));
    add_item(CMD_LIST, 8'(CH_0 + 6));
    add_item(CMD_LIST, CH_COMMA);
    add_item(CMD_LIST, CH_0);
    add_item(CMD_LIST, CH_RBRACK);
    add_item(CMD_LIST, CH_COMMA);
    add_item(CMD_LIST, 8'hFF);
    add_item(CMD_FUNC, CH_R);
    add_item(CMD_LIST, 8'(CH_0 + 7));
    add_item(CMD_LIST, CH_COMMA);
    add_item(CMD_FUNC, CH_Q);
    add_item(CMD_FUNC, CH_D);
    add_item(CMD_DRAIN, 8'h00);
    add_item(CMD_DRAIN, 8'hFF);
    add_item(CMD_DRAIN, CH_X);
    add_item(CMD_FUNC, CH_D);
    add_item(CMD_FUNC, CH_R);
    add_item(CMD_LIST, CH_9);
    add_item(CMD_LIST, CH_COMMA);
    add_item(CMD_DRAIN, 8'h00);
    add_item(CMD_CLEAR, 8'hFF);

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      while (pending_items.size() < PHASE_ITEMS) add_case();
      do @(negedge clk); while (pending_items.size() != 0);
    end

    do @(negedge clk); while (in_valid || expected_results.size() != 0);
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
